// File: sv/lcdw_pkg.sv
`timescale 1ns / 1ps

package lcdw_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_SET_POS = 2'd1;
    localparam logic [1:0] KIND_RAW_CMD = 2'd2;
    localparam logic [1:0] KIND_HOME    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BACKLIGHT = 2'd0;
    localparam logic [1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [1:0] CFG_LINES     = 2'd2;

    localparam int          MAX_COLUMNS_DEF  = 40;
    localparam logic [5:0]  COLUMNS_RST      = 6'd16;
    localparam logic [2:0]  LINES_RST        = 3'd2;
    localparam logic [7:0]  CMD_SET_ADDR     = 8'h80;

    // Expander byte bit positions
    localparam int BIT_RS = 0;
    localparam int BIT_RW = 1;
    localparam int BIT_EN = 2;
    localparam int BIT_BL = 3;

    // LCD request queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] target_column;
        logic [1:0] target_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last_byte;
    } out_item_t;

    // One byte bound for the LCD
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       rs;
        logic       last;
    } lcd_req_t;

    // Zero, one or two requests produced by one item
    typedef struct packed {
        logic [1:0] cnt;
        lcd_req_t   req0;
        lcd_req_t   req1;
    } lcd_push_t;

    function automatic logic [6:0] line_base(input logic [1:0] line);
        logic [6:0] base;
        case (line)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            2'd3:    base = 7'h54;
            default: base = 7'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] set_addr_cmd(input logic [1:0] line, input logic [5:0] col);
        logic [6:0] addr;
        addr = line_base(line) + {1'b0, col};
        return CMD_SET_ADDR | {1'b0, addr};
    endfunction

endpackage

// File: sv/lcdw_front.sv
`timescale 1ns / 1ps

module lcdw_front
    import lcdw_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_item_t   item,
    input  logic [5:0] num_columns,
    input  logic [2:0] num_lines,
    output lcd_push_t  push
);

    logic [5:0] col_reg, col_next;
    logic [1:0] line_reg, line_next;
    logic [5:0] eff_cols;
    logic [6:0] col_inc;
    logic [2:0] line_inc;
    logic [1:0] line_wrap;

    assign eff_cols = (num_columns > 6'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : num_columns;
    assign col_inc  = {1'b0, col_reg} + 7'd1;
    assign line_inc = {1'b0, line_reg} + 3'd1;
    assign line_wrap = (line_inc >= num_lines || line_inc > 3'd3) ? 2'd0 : line_inc[1:0];

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        push      = '0;
        case (item.kind)
            KIND_CHAR:
            begin
                push.req0.lcd_byte = item.data_byte;
                push.req0.rs       = 1'b1;
                if (col_inc >= {1'b0, eff_cols})
                begin
                    // wrap to the next line and, unless the width is zero, re-address the display
                    col_next  = 6'd0;
                    line_next = line_wrap;
                    if (eff_cols != 6'd0)
                    begin
                        push.cnt           = 2'd2;
                        push.req1.lcd_byte = set_addr_cmd(line_wrap, 6'd0);
                        push.req1.last     = 1'b1;
                    end
                    else
                    begin
                        push.cnt       = 2'd1;
                        push.req0.last = 1'b1;
                    end
                end
                else
                begin
                    col_next       = col_inc[5:0];
                    push.cnt       = 2'd1;
                    push.req0.last = 1'b1;
                end
            end
            KIND_SET_POS:
            begin
                // drop the request when the column is off screen
                if (item.target_column < eff_cols)
                begin
                    col_next           = item.target_column;
                    line_next          = item.target_line;
                    push.cnt           = 2'd1;
                    push.req0.lcd_byte = set_addr_cmd(item.target_line, item.target_column);
                    push.req0.last     = 1'b1;
                end
            end
            KIND_RAW_CMD:
            begin
                push.cnt           = 2'd1;
                push.req0.lcd_byte = item.data_byte;
                push.req0.last     = 1'b1;
            end
            KIND_HOME:
            begin
                col_next           = 6'd0;
                line_next          = 2'd0;
                push.cnt           = 2'd1;
                push.req0.lcd_byte = item.data_byte;
                push.req0.last     = 1'b1;
            end
            default:
            begin
                push = '0;
            end
        endcase
        if (!accept)
        begin
            push.cnt  = 2'd0;
            col_next  = col_reg;
            line_next = line_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= 6'd0;
            line_reg <= 2'd0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

// File: sv/lcdw_queue.sv
`timescale 1ns / 1ps

module lcdw_queue
    import lcdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lcd_push_t push,
    input  logic      pop,
    output logic      room,
    output logic      head_valid,
    output lcd_req_t  head
);

    lcd_req_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_p1;

    assign wr_ptr_p1   = wr_ptr_reg + QPTR_W'(1);
    // room for the two requests an item may produce
    assign room        = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign head_valid  = count_reg != '0;
    assign head        = entries_reg[rd_ptr_reg];
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.req0;
        end
        if (push.cnt == 2'd2)
        begin
            entries_reg[wr_ptr_p1] <= push.req1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/lcdw_back.sv
`timescale 1ns / 1ps

module lcdw_back
    import lcdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      backlight_on,
    input  logic      head_valid,
    input  lcd_req_t  head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [1:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    out_item_t  data_reg, data_next;
    logic       advance;
    logic [3:0] nibble;

    assign advance = !valid_reg || !out_stall;
    assign pop     = advance && head_valid && (phase_reg == 2'd3);
    // phases: high nibble EN up, EN down, then low nibble the same way
    assign nibble  = phase_reg[1] ? head.lcd_byte[3:0] : head.lcd_byte[7:4];

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (advance)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                phase_next                      = phase_reg + 2'd1;
                data_next.expander_byte         = {nibble, 4'd0};
                data_next.expander_byte[BIT_BL] = backlight_on;
                data_next.expander_byte[BIT_EN] = !phase_reg[0];
                data_next.expander_byte[BIT_RW] = 1'b0;
                data_next.expander_byte[BIT_RS] = head.rs;
                data_next.last_byte             = head.last && (phase_reg == 2'd3);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/char_lcd_nibble_writer_with_cursor.sv
`timescale 1ns / 1ps
// Character LCD writer for a 4-bit display behind an I2C port expander.
// Input channel (in_valid/in_stall/in_data): one request per item: write a
// character, set the cursor, send a raw command, or send a homing command.
// Output channel (out_valid/out_stall/out_data): expander bytes, four per
// LCD byte (high nibble EN up, EN down, low nibble EN up, EN down);
// last_byte marks the final byte of an item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): backlight,
// column count and line count; always ready, write only while idle.
// Throughput: one expander byte per cycle while the queue holds a byte
// and out_stall is low, four bytes per item, eight when a character
// wraps the line and a set-address command follows; a set position off
// screen produces nothing. A four-entry LCD byte queue sits between the
// item decoder and the nibble sequencer; in_stall rises when fewer than
// two entries are free.
// Reset: cursor to line 0, column 0, backlight on, 16 columns, 2 lines,
// queue and output empty. A stalled output holds its byte and the
// sequencer waits; the queue then fills and stalls the input.
module char_lcd_nibble_writer_with_cursor
    import lcdw_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    logic       backlight_reg;
    logic [5:0] columns_reg;
    logic [2:0] lines_reg;
    logic       room;
    logic       accept;
    lcd_push_t  push;
    logic       pop;
    logic       head_valid;
    lcd_req_t   head;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign accept    = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b1;
            columns_reg   <= COLUMNS_RST;
            lines_reg     <= LINES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BACKLIGHT: backlight_reg <= cfg_data[0];
                CFG_COLUMNS:   columns_reg   <= cfg_data;
                CFG_LINES:     lines_reg     <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    lcdw_front #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_data),
        .num_columns (columns_reg),
        .num_lines   (lines_reg),
        .push        (push)
    );

    lcdw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .backlight_on (backlight_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    // an item's bytes come out without gaps once the first one is taken
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_byte |=> out_valid)
        else $error("gap inside an item's byte sequence");

    // every EN-high byte is followed by its EN-low strobe
    a_en_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.expander_byte[BIT_EN]
        |=> out_valid && !out_data.expander_byte[BIT_EN])
        else $error("EN strobe not followed by its falling byte");

    // the final byte of an item always has EN and RW low
    a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_byte |-> !out_data.expander_byte[BIT_EN]
        && !out_data.expander_byte[BIT_RW])
        else $error("last byte of an item with EN or RW set");

endmodule

// File: sim/char_lcd_nibble_writer_with_cursor_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_writer_with_cursor_tb;
    import lcdw_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_BACKLIGHT;
    logic [5:0] cfg_data = '0;

    // Shadow of the block's configuration and cursor
    logic       cfg_backlight;
    logic [5:0] cfg_columns;
    logic [2:0] cfg_lines;
    logic [5:0] cur_col;
    logic [1:0] cur_line;

    out_item_t expected_bytes[$];
    int        mismatch_count = 0;
    int        idle_pct = 30;
    int        stall_pct = 30;

    char_lcd_nibble_writer_with_cursor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [5:0] visible_width();
        if (cfg_columns > MAX_COLUMNS_DEF)
            return 6'(MAX_COLUMNS_DEF);
        return cfg_columns;
    endfunction

    function automatic logic [7:0] ddram_cmd(input logic [1:0] line, input logic [5:0] col);
        logic [6:0] base;
        logic [6:0] addr;
        case (line)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        addr = base + {1'b0, col};
        return CMD_SET_ADDR | {1'b0, addr};
    endfunction

    // Work out the expander bytes of one request and advance the cursor
    task automatic predict_expander_bytes(input in_item_t req);
        logic [7:0] lcd_val [2];
        logic       lcd_rs [2];
        int         n;
        logic [5:0] width;
        logic [6:0] next_col;
        logic [2:0] next_line;
        logic [3:0] nib;
        out_item_t  ob;
        n = 0;
        width = visible_width();
        case (req.kind)
            KIND_CHAR:
            begin
                lcd_val[0] = req.data_byte;
                lcd_rs[0] = 1'b1;
                n = 1;
                next_col = {1'b0, cur_col} + 7'd1;
                if (next_col >= {1'b0, width})
                begin
                    next_line = {1'b0, cur_line} + 3'd1;
                    if (next_line >= cfg_lines || next_line > 3'd3)
                        next_line = 3'd0;
                    cur_col = '0;
                    cur_line = next_line[1:0];
                    // zero width: column 0 is off screen, so no address follows
                    if (width != 0)
                    begin
                        lcd_val[1] = ddram_cmd(next_line[1:0], 6'd0);
                        lcd_rs[1] = 1'b0;
                        n = 2;
                    end
                end
                else
                    cur_col = next_col[5:0];
            end
            KIND_SET_POS:
            begin
                if (req.target_column < width)
                begin
                    cur_col = req.target_column;
                    cur_line = req.target_line;
                    lcd_val[0] = ddram_cmd(req.target_line, req.target_column);
                    lcd_rs[0] = 1'b0;
                    n = 1;
                end
            end
            KIND_RAW_CMD:
            begin
                lcd_val[0] = req.data_byte;
                lcd_rs[0] = 1'b0;
                n = 1;
            end
            default:
            begin
                lcd_val[0] = req.data_byte;
                lcd_rs[0] = 1'b0;
                n = 1;
                cur_col = '0;
                cur_line = '0;
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                nib = (k < 2) ? lcd_val[i][7:4] : lcd_val[i][3:0];
                ob.expander_byte = {nib, cfg_backlight, (k % 2 == 0), 1'b0, lcd_rs[i]};
                ob.last_byte = (i == n - 1) && (k == 3);
                expected_bytes.push_back(ob);
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %02h last %0b", $time,
                         out_data.expander_byte, out_data.last_byte);
                mismatch_count++;
            end
            else
            begin
                exp_item = expected_bytes.pop_front();
                if (out_data.expander_byte !== exp_item.expander_byte)
                begin
                    $display("%0t: expander_byte expected %02h got %02h", $time,
                             exp_item.expander_byte, out_data.expander_byte);
                    mismatch_count++;
                end
                if (out_data.last_byte !== exp_item.last_byte)
                begin
                    $display("%0t: last_byte expected %0b got %0b", $time,
                             exp_item.last_byte, out_data.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic in_item_t make_request(input logic [1:0] kind, input logic [7:0] data,
                                              input logic [5:0] col, input logic [1:0] line);
        in_item_t req;
        req.kind = kind;
        req.data_byte = data;
        req.target_column = col;
        req.target_line = line;
        return req;
    endfunction

    // Enter and leave at a falling edge; valid stays high for a following request
    task automatic send_request(input in_item_t req);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_stall);
        predict_expander_bytes(req);
        @(negedge clk);
    endtask

    // Hold the input off until every expected byte has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [5:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BACKLIGHT: cfg_backlight = value[0];
            CFG_COLUMNS:   cfg_columns = value;
            CFG_LINES:     cfg_lines = value[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_each_kind();
        send_request(make_request(KIND_CHAR, 8'h00, 6'd0, 2'd0));
        send_request(make_request(KIND_CHAR, 8'hFF, 6'd63, 2'd3));
        send_request(make_request(KIND_RAW_CMD, 8'h5A, 6'd21, 2'd2));
        send_request(make_request(KIND_HOME, 8'h02, 6'd42, 2'd1));
        send_request(make_request(KIND_SET_POS, 8'hC3, 6'd15, 2'd3));
        // off screen: dropped
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd16, 2'd1));
        send_request(make_request(KIND_SET_POS, 8'hFF, 6'd63, 2'd2));
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd0, 2'd1));
        send_request(make_request(KIND_CHAR, 8'hA5, 6'd0, 2'd0));
    endtask

    task automatic test_line_wrap();
        write_cfg(CFG_COLUMNS, 6'd1);
        write_cfg(CFG_LINES, 6'd4);
        repeat (4) send_request(make_request(KIND_CHAR, 8'h41, 6'd0, 2'd0));
        write_cfg(CFG_LINES, 6'd0);
        send_request(make_request(KIND_CHAR, 8'h42, 6'd0, 2'd0));
        write_cfg(CFG_LINES, 6'd7);
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd0, 2'd3));
        send_request(make_request(KIND_CHAR, 8'h43, 6'd0, 2'd0));
    endtask

    task automatic test_width_extremes();
        write_cfg(CFG_COLUMNS, 6'd0);
        send_request(make_request(KIND_CHAR, 8'h30, 6'd0, 2'd0));
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd0, 2'd0));
        write_cfg(CFG_COLUMNS, 6'd63);
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd39, 2'd3));
        send_request(make_request(KIND_CHAR, 8'h31, 6'd0, 2'd0));
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd40, 2'd0));
        write_cfg(CFG_COLUMNS, 6'd40);
        send_request(make_request(KIND_SET_POS, 8'h00, 6'd39, 2'd1));
        send_request(make_request(KIND_CHAR, 8'h32, 6'd0, 2'd0));
        write_cfg(CFG_BACKLIGHT, 6'd0);
        send_request(make_request(KIND_RAW_CMD, 8'hFF, 6'd0, 2'd0));
        // unmapped index: no effect
        write_cfg(CFG_UNUSED, 6'd63);
        send_request(make_request(KIND_CHAR, 8'h3C, 6'd0, 2'd0));
        write_cfg(CFG_BACKLIGHT, 6'd1);
    endtask

    function automatic in_item_t random_request();
        in_item_t   req;
        int         pick;
        logic [5:0] width;
        pick = $urandom_range(99);
        width = visible_width();
        req.data_byte = 8'($urandom_range(255));
        req.target_column = 6'($urandom_range(63));
        req.target_line = 2'($urandom_range(3));
        if (pick < 50)
            req.kind = KIND_CHAR;
        else if (pick < 75)
            req.kind = KIND_SET_POS;
        else if (pick < 90)
            req.kind = KIND_RAW_CMD;
        else
            req.kind = KIND_HOME;
        // mostly on-screen positions
        if (req.kind == KIND_SET_POS && width != 0 && $urandom_range(99) < 80)
            req.target_column = 6'($urandom_range(32'(width) - 1));
        return req;
    endfunction

    task automatic test_random_traffic();
        int         pick;
        logic [5:0] cols;
        for (int phase = 0; phase < 6; phase++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                cols = 6'($urandom_range(1, 8));
            else if (pick < 85)
                cols = 6'($urandom_range(9, 40));
            else if (pick < 92)
                cols = 6'd0;
            else
                cols = 6'($urandom_range(41, 63));
            write_cfg(CFG_BACKLIGHT, 6'($urandom_range(1)));
            write_cfg(CFG_COLUMNS, cols);
            write_cfg(CFG_LINES, 6'($urandom_range(7)));
            idle_pct = (phase == 2) ? 0 : 30;
            stall_pct = (phase == 2) ? 0 : 30;
            for (int i = 0; i < 75; i++)
            begin
                if (phase == 4 && i == 37)
                    wait_idle();
                send_request(random_request());
            end
        end
        idle_pct = 30;
        stall_pct = 30;
    endtask

    initial
    begin
        cfg_backlight = 1'b1;
        cfg_columns = COLUMNS_RST;
        cfg_lines = LINES_RST;
        cur_col = '0;
        cur_line = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_each_kind();
        test_line_wrap();
        test_width_extremes();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
